// ----- sv/pedist_pkg.sv -----
`timescale 1ns / 1ps
package pedist_pkg;

  // request codes
  localparam logic [1:0] REQ_LOAD_A  = 2'd0;
  localparam logic [1:0] REQ_LOAD_B  = 2'd1;
  localparam logic [1:0] REQ_COMPUTE = 2'd2;

  // register indexes
  localparam logic CFG_LEN_A = 1'b0;
  localparam logic CFG_LEN_B = 1'b1;

  localparam int PROB_W   = 16;
  localparam int PROD_W   = 2 * PROB_W;
  localparam int DIST_W   = 27;
  localparam int SUM_W    = 30;
  localparam int GAP_W    = 19;
  localparam int MSUM_W   = 19;
  localparam int REM_W    = PROB_W + 2;
  localparam int SQ_CNT_W = 4;
  localparam int LEN_W    = 9;
  localparam logic [SQ_CNT_W-1:0] SQ_LAST = SQ_CNT_W'(PROB_W - 1);
  localparam logic signed [SUM_W-1:0] Q_TWO = SUM_W'(65536);
  localparam logic signed [SUM_W-1:0] DIST_MAX = SUM_W'(67108863);
  localparam logic signed [SUM_W-1:0] DIST_MIN = -SUM_W'(67108864);

  typedef enum logic [3:0] {
    ST_IDLE, ST_ZERO, ST_RD, ST_MUL, ST_SQ, ST_ACC, ST_ROWRD, ST_UPD, ST_DONE
  } state_t;

  typedef enum logic [1:0] {PH_INIT, PH_ROW0, PH_CELL} phase_t;

  typedef enum logic [2:0] {UPD_NONE, UPD_ZERO, UPD_INIT, UPD_ROW0, UPD_CELL} upd_t;

  typedef struct packed {
    logic ld_a;
    logic ld_b;
    logic prof_rd;
    logic clr_ga;
    logic clr_cell;
    logic mul;
    logic acc_ga;
    logic acc_gb;
    logic sq_step;
    logic sq_acc;
    logic row_rd;
    upd_t upd;
    logic out_load;
  } cmd_t;

endpackage

// ----- sv/pedist_dp.sv -----
`timescale 1ns / 1ps
module pedist_dp import pedist_pkg::*; #(
  parameter int MAX_LEN     = 256,
  parameter int PROFILE_DIM = 3,
  parameter int SW          = 10,
  parameter int LW          = 9
) (
  input  logic              clk,
  input  logic              rst,
  input  cmd_t              cmd,
  input  logic [SW-1:0]     a_addr,
  input  logic [SW-1:0]     b_addr,
  input  logic [LW-1:0]     row_addr,
  input  logic [7:0]        position,
  input  logic [1:0]        component,
  input  logic [PROB_W-1:0] prob,
  output logic [DIST_W-1:0] distance,
  output logic              saturated
);

  localparam int STORE_DEPTH = MAX_LEN * PROFILE_DIM;
  localparam int ROW_DEPTH   = MAX_LEN + 1;

  logic [PROB_W-1:0] mem_a [STORE_DEPTH];
  logic [PROB_W-1:0] mem_b [STORE_DEPTH];
  logic signed [DIST_W-1:0] row_mem [ROW_DEPTH];

  logic [PROB_W-1:0] a_q;
  logic [PROB_W-1:0] b_q;
  logic signed [DIST_W-1:0] row_q;
  logic [PROD_W-1:0] sq_x;
  logic [REM_W-1:0]  sq_rem;
  logic [PROB_W-1:0] sq_root;
  logic [GAP_W-1:0]  ga;
  logic [GAP_W-1:0]  gb;
  logic [MSUM_W-1:0] msum;
  logic signed [DIST_W-1:0] left;
  logic signed [DIST_W-1:0] diag;
  logic sat;

  logic ld_ok;
  logic [SW-1:0] ld_idx;
  logic [REM_W+1:0] rem_t;
  logic [REM_W+1:0] trial;
  logic signed [SUM_W-1:0] up_v, left_v, chg_v, min_v, sel_v, clip_v;
  logic clip_hit;
  logic do_write;

  // load address and range check
  assign ld_ok  = (32'(position) < MAX_LEN) && (32'(component) < PROFILE_DIM);
  assign ld_idx = SW'(32'(position) * PROFILE_DIM + 32'(component));

  // profile stores
  always_ff @(posedge clk) begin
    if (cmd.ld_a && ld_ok) mem_a[ld_idx] <= prob;
    if (cmd.ld_b && ld_ok) mem_b[ld_idx] <= prob;
    if (cmd.prof_rd) begin
      a_q <= mem_a[a_addr];
      b_q <= mem_b[b_addr];
    end
  end

  // one root digit per step
  assign rem_t = {sq_rem, sq_x[PROD_W-1 -: 2]};
  assign trial = (REM_W+2)'({sq_root, 2'b01});

  // cell candidates
  assign up_v   = SUM_W'(row_q) + $signed(SUM_W'(ga));
  assign left_v = SUM_W'(left) + $signed(SUM_W'(gb));
  assign chg_v  = SUM_W'(diag) + Q_TWO - $signed(SUM_W'({msum, 1'b0}));

  always_comb begin
    min_v = up_v;
    if (left_v < min_v) min_v = left_v;
    if (chg_v < min_v) min_v = chg_v;
    case (cmd.upd)
      UPD_INIT: sel_v = left_v;
      UPD_ROW0: sel_v = up_v;
      UPD_CELL: sel_v = min_v;
      default:  sel_v = '0;
    endcase
    clip_hit = 1'b0;
    clip_v   = sel_v;
    if (sel_v > DIST_MAX) begin
      clip_v   = DIST_MAX;
      clip_hit = 1'b1;
    end else if (sel_v < DIST_MIN) begin
      clip_v   = DIST_MIN;
      clip_hit = 1'b1;
    end
  end

  assign do_write = (cmd.upd != UPD_NONE);

  // row buffer
  always_ff @(posedge clk) begin
    if (cmd.row_rd) row_q <= row_mem[row_addr];
    if (do_write) row_mem[row_addr] <= DIST_W'(clip_v);
  end

  // arithmetic registers
  always_ff @(posedge clk) begin
    if (cmd.clr_ga) ga <= '0;
    else if (cmd.acc_ga) ga <= ga + GAP_W'(a_q);
    if (cmd.clr_cell) begin
      gb   <= '0;
      msum <= '0;
    end else begin
      if (cmd.acc_gb) gb <= gb + GAP_W'(b_q);
      if (cmd.sq_acc) msum <= msum + MSUM_W'(sq_root);
    end
    if (cmd.mul) begin
      sq_x    <= a_q * b_q;
      sq_rem  <= '0;
      sq_root <= '0;
    end else if (cmd.sq_step) begin
      sq_x <= {sq_x[PROD_W-3:0], 2'b00};
      if (rem_t >= trial) begin
        sq_rem  <= REM_W'(rem_t - trial);
        sq_root <= {sq_root[PROB_W-2:0], 1'b1};
      end else begin
        sq_rem  <= REM_W'(rem_t);
        sq_root <= {sq_root[PROB_W-2:0], 1'b0};
      end
    end
    if (cmd.upd == UPD_ROW0 || cmd.upd == UPD_CELL) diag <= row_q;
    if (do_write) left <= DIST_W'(clip_v);
    if (cmd.out_load) distance <= left;
  end

  // sticky clip flag
  always_ff @(posedge clk) begin
    if (rst) begin
      sat       <= 1'b0;
      saturated <= 1'b0;
    end else begin
      if (cmd.upd == UPD_ZERO) sat <= 1'b0;
      else if (do_write && clip_hit) sat <= 1'b1;
      if (cmd.out_load) saturated <= sat;
    end
  end

endmodule

// ----- sv/pedist_ctrl.sv -----
`timescale 1ns / 1ps
module pedist_ctrl import pedist_pkg::*; #(
  parameter int MAX_LEN     = 256,
  parameter int PROFILE_DIM = 3,
  parameter int SW          = 10,
  parameter int LW          = 9
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  input  logic [1:0]       req_type,
  output logic             m_tvalid,
  input  logic             m_tready,
  input  logic             cfg_we,
  input  logic             cfg_index,
  input  logic [LEN_W-1:0] cfg_data,
  output cmd_t             cmd,
  output logic [SW-1:0]    a_addr,
  output logic [SW-1:0]    b_addr,
  output logic [LW-1:0]    row_addr
);

  localparam int KW = (PROFILE_DIM > 1) ? $clog2(PROFILE_DIM) : 1;
  localparam logic [KW-1:0] K_LAST = KW'(PROFILE_DIM - 1);

  state_t state, state_next;
  phase_t phase, phase_next;
  logic [LW-1:0] i, i_next, j, j_next, na, na_next, nb, nb_next;
  logic [KW-1:0] k, k_next;
  logic [SQ_CNT_W-1:0] sq_cnt, sq_cnt_next;
  logic [LEN_W-1:0] len_a, len_b;
  logic m_tvalid_next;
  logic accept;

  assign accept = s_tvalid && s_tready;

  // profile addresses of the current position pair
  assign a_addr = SW'((32'(i) - 32'd1) * PROFILE_DIM + 32'(k));
  assign b_addr = SW'((32'(j) - 32'd1) * PROFILE_DIM + 32'(k));

  // length registers
  always_ff @(posedge clk) begin
    if (rst) begin
      len_a <= '0;
      len_b <= '0;
    end else if (cfg_we) begin
      if (cfg_index == CFG_LEN_A) len_a <= cfg_data;
      if (cfg_index == CFG_LEN_B) len_b <= cfg_data;
    end
  end

  // state and counters
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      phase    <= PH_INIT;
      i        <= '0;
      j        <= '0;
      k        <= '0;
      na       <= '0;
      nb       <= '0;
      sq_cnt   <= '0;
      m_tvalid <= 1'b0;
    end else begin
      state    <= state_next;
      phase    <= phase_next;
      i        <= i_next;
      j        <= j_next;
      k        <= k_next;
      na       <= na_next;
      nb       <= nb_next;
      sq_cnt   <= sq_cnt_next;
      m_tvalid <= m_tvalid_next;
    end
  end

  // sequencer
  always_comb begin
    state_next    = state;
    phase_next    = phase;
    i_next        = i;
    j_next        = j;
    k_next        = k;
    na_next       = na;
    nb_next       = nb;
    sq_cnt_next   = sq_cnt;
    m_tvalid_next = m_tvalid && !m_tready;
    s_tready      = 1'b0;
    cmd           = '0;
    cmd.upd       = UPD_NONE;
    row_addr      = (phase == PH_ROW0) ? '0 : j;
    case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        if (accept) begin
          if (req_type == REQ_LOAD_A) cmd.ld_a = 1'b1;
          if (req_type == REQ_LOAD_B) cmd.ld_b = 1'b1;
          if (req_type == REQ_COMPUTE) begin
            na_next    = (32'(len_a) > MAX_LEN) ? LW'(MAX_LEN) : LW'(len_a);
            nb_next    = (32'(len_b) > MAX_LEN) ? LW'(MAX_LEN) : LW'(len_b);
            state_next = ST_ZERO;
          end
        end
      end
      ST_ZERO: begin
        cmd.upd  = UPD_ZERO;
        row_addr = '0;
        k_next   = '0;
        j_next   = LW'(1);
        i_next   = LW'(1);
        if (nb != '0) begin
          phase_next = PH_INIT;
          state_next = ST_RD;
        end else if (na != '0) begin
          phase_next = PH_ROW0;
          state_next = ST_RD;
        end else begin
          state_next = ST_DONE;
        end
      end
      ST_RD: begin
        cmd.prof_rd = 1'b1;
        if (k == '0) begin
          cmd.clr_ga   = (phase == PH_ROW0);
          cmd.clr_cell = (phase != PH_ROW0);
        end
        state_next = ST_MUL;
      end
      ST_MUL: begin
        cmd.mul    = 1'b1;
        cmd.acc_ga = (phase == PH_ROW0);
        cmd.acc_gb = (phase != PH_ROW0);
        sq_cnt_next = '0;
        state_next = (phase == PH_CELL) ? ST_SQ : ST_ACC;
      end
      ST_SQ: begin
        cmd.sq_step = 1'b1;
        sq_cnt_next = sq_cnt + 1'b1;
        if (sq_cnt == SQ_LAST) state_next = ST_ACC;
      end
      ST_ACC: begin
        cmd.sq_acc = (phase == PH_CELL);
        if (k == K_LAST) begin
          k_next     = '0;
          state_next = ST_ROWRD;
        end else begin
          k_next     = k + 1'b1;
          state_next = ST_RD;
        end
      end
      ST_ROWRD: begin
        cmd.row_rd = 1'b1;
        state_next = ST_UPD;
      end
      ST_UPD: begin
        state_next = ST_RD;
        case (phase)
          PH_INIT: begin
            cmd.upd = UPD_INIT;
            if (j == nb) begin
              if (na == '0) state_next = ST_DONE;
              else begin
                i_next     = LW'(1);
                phase_next = PH_ROW0;
              end
            end else begin
              j_next = j + 1'b1;
            end
          end
          PH_ROW0: begin
            cmd.upd = UPD_ROW0;
            if (nb == '0) begin
              if (i == na) state_next = ST_DONE;
              else i_next = i + 1'b1;
            end else begin
              j_next     = LW'(1);
              phase_next = PH_CELL;
            end
          end
          PH_CELL: begin
            cmd.upd = UPD_CELL;
            if (j == nb) begin
              if (i == na) state_next = ST_DONE;
              else begin
                i_next     = i + 1'b1;
                phase_next = PH_ROW0;
              end
            end else begin
              j_next = j + 1'b1;
            end
          end
          default: state_next = ST_IDLE;
        endcase
      end
      ST_DONE: begin
        if (!m_tvalid || m_tready) begin
          cmd.out_load  = 1'b1;
          m_tvalid_next = 1'b1;
          state_next    = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

// ----- sv/profile_edit_distance_core.sv -----
`timescale 1ns / 1ps
// Global alignment distance between two probability profiles. Load beats
// (req_type 0 or 1) write one Q1.15 component into profile A or B; they give
// no result. A compute beat (req_type 2) runs the row-buffered dynamic program
// and returns one distance beat with a sticky saturation flag in tuser. Every
// profile read, component product and 16-step digit-by-digit square root runs
// through one shared datapath, and no input beat is taken until a compute
// finishes. The result sits in an output register, so loads go on while it
// waits.
module profile_edit_distance_core import pedist_pkg::*; #(
  parameter int MAX_LEN     = 256,
  parameter int PROFILE_DIM = 3
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // req_type[1:0], position[9:2], component[11:10], prob[27:12], zero pad
  input  logic [31:0] s_tdata,
  output logic        m_tvalid,
  input  logic        m_tready,
  // distance[26:0], zero pad
  output logic [31:0] m_tdata,
  // saturated[0]
  output logic        m_tuser,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [8:0]  cfg_data
);

  localparam int SW = (MAX_LEN * PROFILE_DIM > 1) ? $clog2(MAX_LEN * PROFILE_DIM) : 1;
  localparam int LW = $clog2(MAX_LEN + 1);

  cmd_t cmd;
  logic [SW-1:0] a_addr, b_addr;
  logic [LW-1:0] row_addr;
  logic [DIST_W-1:0] distance;

  pedist_ctrl #(
    .MAX_LEN(MAX_LEN), .PROFILE_DIM(PROFILE_DIM), .SW(SW), .LW(LW)
  ) u_ctrl (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .req_type(s_tdata[1:0]),
    .m_tvalid(m_tvalid), .m_tready(m_tready),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .cmd(cmd), .a_addr(a_addr), .b_addr(b_addr), .row_addr(row_addr)
  );

  pedist_dp #(
    .MAX_LEN(MAX_LEN), .PROFILE_DIM(PROFILE_DIM), .SW(SW), .LW(LW)
  ) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd),
    .a_addr(a_addr), .b_addr(b_addr), .row_addr(row_addr),
    .position(s_tdata[9:2]), .component(s_tdata[11:10]), .prob(s_tdata[27:12]),
    .distance(distance), .saturated(m_tuser)
  );

  assign m_tdata = {5'b0, distance};

endmodule
